/* src/sel_pkg.sv */
// ============================================================================
// sel_pkg - shared types and constants of the S-expression lexer
// Character codes, token kinds, lexer modes, the result item type and the
// byte classification functions.
// ============================================================================
package sel_pkg;

    // Default width of the constant accumulator
    localparam int VALUE_BITS_DEF = 32;
    // Output queue depth (power of two, at least the two results of one item)
    localparam int OQ_DEPTH = 4;

    // Character codes
    localparam logic [7:0] CH_OPEN  = 8'h28;  // (
    localparam logic [7:0] CH_CLOSE = 8'h29;  // )
    localparam logic [7:0] CH_DOT   = 8'h2E;  // .
    localparam logic [7:0] CH_QUOTE = 8'h27;  // '
    localparam logic [7:0] CH_PLUS  = 8'h2B;  // +
    localparam logic [7:0] CH_MINUS = 8'h2D;  // -
    localparam logic [7:0] CH_LT    = 8'h3C;  // <
    localparam logic [7:0] CH_EQ    = 8'h3D;  // =
    localparam logic [7:0] CH_GT    = 8'h3E;  // >
    localparam logic [7:0] CH_STAR  = 8'h2A;  // *
    localparam logic [7:0] CH_SLASH = 8'h2F;  // /
    localparam logic [7:0] CH_HASH  = 8'h23;  // #
    localparam logic [7:0] CH_QMARK = 8'h3F;  // ?
    localparam logic [7:0] CH_BANG  = 8'h21;  // !
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_Z  = 8'h5A;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_Z  = 8'h7A;

    // Token kinds
    typedef enum logic [2:0] {
        KIND_OPEN  = 3'd0,
        KIND_CLOSE = 3'd1,
        KIND_DOT   = 3'd2,
        KIND_QUOTE = 3'd3,
        KIND_SYM   = 3'd4,
        KIND_CONST = 3'd5,
        KIND_ERR   = 3'd6,
        KIND_END   = 3'd7
    } t_kind;

    // Lexer modes; codes 5..7 behave as idle
    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_SIGN   = 3'd1,
        MODE_NUMBER = 3'd2,
        MODE_SYMBOL = 3'd3,
        MODE_ERROR  = 3'd4
    } t_mode;

    // One result item
    typedef struct packed {
        t_kind              kind;
        logic [7:0]         name_char;
        logic               name_last;
        logic signed [31:0] value;
    } t_result;

    // Results of one step: count (0..2) and up to two items in order
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_step;

    function automatic t_result mk_res(t_kind kind, logic [7:0] c, logic last,
                                       logic [31:0] val);
        t_result r;
        r.kind      = kind;
        r.name_char = c;
        r.name_last = last;
        r.value     = val;
        return r;
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return ((c >= CH_LC_A) && (c <= CH_LC_Z)) || ((c >= CH_UC_A) && (c <= CH_UC_Z));
    endfunction

    function automatic logic sym_first(logic [7:0] c);
        return is_alpha(c) || (c == CH_LT) || (c == CH_EQ) || (c == CH_GT)
            || (c == CH_STAR) || (c == CH_SLASH) || (c == CH_HASH);
    endfunction

    function automatic logic sym_rest(logic [7:0] c);
        return sym_first(c) || is_digit(c) || (c == CH_QMARK) || (c == CH_BANG)
            || (c == CH_MINUS);
    endfunction

endpackage

/* src/sel_if.sv */
// ============================================================================
// sel_in_if / sel_out_if - item channels of the S-expression lexer
// Valid/ready channels; an item moves when valid and ready are both high.
// ============================================================================
interface sel_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       end_of_text;

    modport source (output valid, output ch, output end_of_text, input ready);
    modport sink   (input valid, input ch, input end_of_text, output ready);
endinterface

interface sel_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         kind;
    logic [7:0]         name_char;
    logic               name_last;
    logic signed [31:0] value;

    modport source (output valid, output kind, output name_char, output name_last,
                    output value, input ready);
    modport sink   (input valid, input kind, input name_char, input name_last,
                    input value, output ready);
endinterface

/* src/sel_core.sv */
// ============================================================================
// sel_core - lexer state and per-byte step logic
// Holds the pending token state and works out, for one accepted item, up to
// two result items and the next state combinationally.
// ============================================================================
module sel_core
    import sel_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_ch,
    input  logic       i_eot,
    output t_step      o_step
);

    localparam int SUM_BITS = VALUE_BITS + 4;
    localparam int EXT_BITS = (VALUE_BITS > 32) ? VALUE_BITS : 32;

    t_mode                 r_mode, n_mode;
    logic [7:0]            r_held, n_held;
    logic [VALUE_BITS-1:0] r_acc,  n_acc;
    logic                  r_neg,  n_neg;
    logic                  r_ovf,  n_ovf;

    // Digit accumulate: acc*10 + d, checked against the signed limit
    logic [VALUE_BITS-1:0] dg_acc_in, dg_acc;
    logic                  dg_neg, dg_ovf_in, dg_ovf, dg_over;
    logic [3:0]            dg_d;
    logic [SUM_BITS-1:0]   dg_sum, dg_limit;

    always_comb begin
        unique case (r_mode)
            MODE_NUMBER: begin
                dg_acc_in = r_acc;
                dg_neg    = r_neg;
                dg_ovf_in = r_ovf;
            end
            MODE_SIGN: begin
                dg_acc_in = '0;
                dg_neg    = (r_held == CH_MINUS);
                dg_ovf_in = 1'b0;
            end
            default: begin
                dg_acc_in = '0;
                dg_neg    = 1'b0;
                dg_ovf_in = 1'b0;
            end
        endcase
        dg_d     = 4'(i_ch - CH_ZERO);
        dg_sum   = (SUM_BITS'(dg_acc_in) << 3) + (SUM_BITS'(dg_acc_in) << 1)
                 + SUM_BITS'(dg_d);
        dg_limit = (SUM_BITS'(1) << (VALUE_BITS - 1)) - SUM_BITS'(1) + SUM_BITS'(dg_neg);
        dg_over  = dg_sum > dg_limit;
        dg_ovf   = dg_ovf_in | dg_over;
        dg_acc   = dg_ovf ? dg_acc_in : dg_sum[VALUE_BITS-1:0];
    end

    // Signed constant from the magnitude, low 32 bits
    logic [EXT_BITS-1:0] cv_ext, cv_val;
    assign cv_ext = EXT_BITS'(r_acc);
    assign cv_val = r_neg ? (EXT_BITS'(0) - cv_ext) : cv_ext;

    // Flush of the pending token
    logic    fl_v;
    t_result fl_res;
    t_mode   fl_mode;

    always_comb begin
        fl_v    = 1'b0;
        fl_res  = mk_res(KIND_END, 8'h00, 1'b0, 32'h0);
        fl_mode = MODE_IDLE;
        unique case (r_mode)
            MODE_SIGN, MODE_SYMBOL: begin
                fl_v   = 1'b1;
                fl_res = mk_res(KIND_SYM, r_held, 1'b1, 32'h0);
            end
            MODE_NUMBER: begin
                fl_v = 1'b1;
                if (r_ovf) begin
                    fl_res  = mk_res(KIND_ERR, 8'h00, 1'b0, 32'h0);
                    fl_mode = MODE_ERROR;
                end else begin
                    fl_res = mk_res(KIND_CONST, 8'h00, 1'b0, cv_val[31:0]);
                end
            end
            MODE_ERROR: fl_mode = MODE_ERROR;
            default:    fl_mode = MODE_IDLE;
        endcase
    end

    // Start of a new token on the current byte
    logic                  st_v;
    t_result               st_res;
    t_mode                 st_mode;
    logic [7:0]            st_held;
    logic [VALUE_BITS-1:0] st_acc;
    logic                  st_neg, st_ovf;

    always_comb begin
        st_v    = 1'b0;
        st_res  = mk_res(KIND_END, 8'h00, 1'b0, 32'h0);
        st_mode = MODE_IDLE;
        st_held = r_held;
        st_acc  = r_acc;
        st_neg  = r_neg;
        st_ovf  = r_ovf;
        if (is_space(i_ch)) begin
            st_v = 1'b0;
        end else if (i_ch == CH_OPEN) begin
            st_v   = 1'b1;
            st_res = mk_res(KIND_OPEN, 8'h00, 1'b0, 32'h0);
        end else if (i_ch == CH_CLOSE) begin
            st_v   = 1'b1;
            st_res = mk_res(KIND_CLOSE, 8'h00, 1'b0, 32'h0);
        end else if (i_ch == CH_DOT) begin
            st_v   = 1'b1;
            st_res = mk_res(KIND_DOT, 8'h00, 1'b0, 32'h0);
        end else if (i_ch == CH_QUOTE) begin
            st_v   = 1'b1;
            st_res = mk_res(KIND_QUOTE, 8'h00, 1'b0, 32'h0);
        end else if ((i_ch == CH_PLUS) || (i_ch == CH_MINUS)) begin
            st_mode = MODE_SIGN;
            st_held = i_ch;
        end else if (is_digit(i_ch)) begin
            // only reached from idle mode, so the digit unit starts fresh
            st_mode = MODE_NUMBER;
            st_acc  = dg_acc;
            st_neg  = 1'b0;
            st_ovf  = dg_ovf;
        end else if (sym_first(i_ch)) begin
            st_mode = MODE_SYMBOL;
            st_held = i_ch;
        end else begin
            st_v    = 1'b1;
            st_res  = mk_res(KIND_ERR, 8'h00, 1'b0, 32'h0);
            st_mode = MODE_ERROR;
        end
    end

    // Step: next state and packed result list
    logic    use_fl, use_st;
    t_result one_res;
    logic    one_v;

    always_comb begin
        n_mode  = r_mode;
        n_held  = r_held;
        n_acc   = r_acc;
        n_neg   = r_neg;
        n_ovf   = r_ovf;
        use_fl  = 1'b0;
        use_st  = 1'b0;
        one_v   = 1'b0;
        one_res = mk_res(KIND_END, 8'h00, 1'b0, 32'h0);

        if (i_eot) begin
            use_fl  = 1'b1;
            one_v   = 1'b1;
            one_res = mk_res(KIND_END, 8'h00, 1'b0, 32'h0);
            n_mode  = MODE_IDLE;
            n_held  = '0;
            n_acc   = '0;
            n_neg   = 1'b0;
            n_ovf   = 1'b0;
        end else begin
            unique case (r_mode)
                MODE_SIGN: begin
                    if (is_digit(i_ch)) begin
                        n_mode = MODE_NUMBER;
                        n_acc  = dg_acc;
                        n_neg  = dg_neg;
                        n_ovf  = dg_ovf;
                    end else begin
                        use_fl = 1'b1;
                        use_st = 1'b1;
                    end
                end
                MODE_NUMBER: begin
                    if (is_digit(i_ch)) begin
                        n_acc = dg_acc;
                        n_ovf = dg_ovf;
                    end else if (r_ovf) begin
                        // error in place of the constant; the ending byte is dropped
                        use_fl = 1'b1;
                        n_mode = fl_mode;
                    end else begin
                        use_fl = 1'b1;
                        use_st = 1'b1;
                    end
                end
                MODE_SYMBOL: begin
                    if (sym_rest(i_ch)) begin
                        one_v   = 1'b1;
                        one_res = mk_res(KIND_SYM, r_held, 1'b0, 32'h0);
                        n_held  = i_ch;
                    end else begin
                        use_fl = 1'b1;
                        use_st = 1'b1;
                    end
                end
                MODE_ERROR: begin
                    n_mode = MODE_ERROR;
                end
                default: begin
                    use_st = 1'b1;
                end
            endcase
            if (use_st) begin
                one_v   = st_v;
                one_res = st_res;
                n_mode  = st_mode;
                n_held  = st_held;
                n_acc   = st_acc;
                n_neg   = st_neg;
                n_ovf   = st_ovf;
            end
        end

        // flush item, when present, goes first
        if (use_fl && fl_v) begin
            o_step.res0  = fl_res;
            o_step.res1  = one_res;
            o_step.count = one_v ? 2'd2 : 2'd1;
        end else begin
            o_step.res0  = one_res;
            o_step.res1  = one_res;
            o_step.count = one_v ? 2'd1 : 2'd0;
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_held <= '0;
            r_acc  <= '0;
            r_neg  <= 1'b0;
            r_ovf  <= 1'b0;
        end else if (i_step) begin
            r_mode <= n_mode;
            r_held <= n_held;
            r_acc  <= n_acc;
            r_neg  <= n_neg;
            r_ovf  <= n_ovf;
        end
    end

endmodule

/* src/sel_outq.sv */
// ============================================================================
// sel_outq - result queue of the S-expression lexer
// Small register queue taking up to two items per cycle and giving one.
// Room for two more items is what lets an input item in.
// ============================================================================
module sel_outq
    import sel_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_step   i_step,
    output logic    o_room,
    output logic    o_valid,
    input  logic    i_pop,
    output t_result o_head
);

    localparam int PTR_BITS = $clog2(OQ_DEPTH);
    localparam int CNT_BITS = $clog2(OQ_DEPTH + 1);

    t_result               r_mem [OQ_DEPTH];
    logic [PTR_BITS-1:0]   r_wr, n_wr, r_rd, n_rd;
    logic [CNT_BITS-1:0]   r_cnt, n_cnt;
    logic [1:0]            push_n;
    logic                  pop_ok;

    assign push_n  = i_push ? i_step.count : 2'd0;
    assign pop_ok  = i_pop && (r_cnt != '0);
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];
    assign o_room  = (r_cnt <= CNT_BITS'(OQ_DEPTH - 2));

    // Pointer and fill bookkeeping
    always_comb begin
        n_wr  = r_wr + PTR_BITS'(push_n);
        n_rd  = pop_ok ? (r_rd + PTR_BITS'(1)) : r_rd;
        n_cnt = r_cnt + CNT_BITS'(push_n) - CNT_BITS'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_mem[r_wr] <= i_step.res0;
        end
        if (push_n == 2'd2) begin
            r_mem[r_wr + PTR_BITS'(1)] <= i_step.res1;
        end
    end

endmodule

/* src/s_expression_lexer_unit.sv */
// ============================================================================
// s_expression_lexer_unit - streaming S-expression tokeniser
// Turns a byte stream into open/close/dot/quote, symbol character, constant,
// error and end tokens, one byte per cycle while the result queue has room.
// ============================================================================
//  channel   dir  payload                               handshake
//  i_in      in   ch[7:0], end_of_text                  valid/ready
//  o_out     out  kind[2:0], name_char[7:0], name_last,  valid/ready
//                 value[31:0] signed
//
//  One byte is taken per cycle while the queue has room; its results enter the
//  result queue at the same clock edge, behind any items already queued.
//  A byte yields zero, one or two items; the queue drains one per cycle while
//  o_out.ready is high, so two-item bytes hold output to one item per cycle.
//  i_in.ready is high while the queue has room for two items (of its four entries).
//  Reset (synchronous, active low) returns the lexer to idle and empties the
//  queue; no clearing pass is needed.
// ============================================================================
module s_expression_lexer_unit
    import sel_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sel_in_if.sink      i_in,
    sel_out_if.source   o_out
);

    logic    step;
    logic    room;
    t_step   step_res;
    t_result head;

    assign i_in.ready = room;
    assign step       = i_in.valid && room;

    // Lexer state and step logic
    sel_core #(
        .VALUE_BITS (VALUE_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_ch    (i_in.ch),
        .i_eot   (i_in.end_of_text),
        .o_step  (step_res)
    );

    // Result queue
    sel_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (step),
        .i_step  (step_res),
        .o_room  (room),
        .o_valid (o_out.valid),
        .i_pop   (o_out.ready),
        .o_head  (head)
    );

    assign o_out.kind      = head.kind;
    assign o_out.name_char = head.name_char;
    assign o_out.name_last = head.name_last;
    assign o_out.value     = head.value;

endmodule

/* src/sel_checker.sv */
// ============================================================================
// sel_checker - port-level checks of the S-expression lexer
// Watches the channels of s_expression_lexer_unit; attached by bind.
// ============================================================================
module sel_checker
    import sel_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  i_out_kind,
    input logic [7:0]  i_out_name_char,
    input logic        i_out_name_last,
    input logic [31:0] i_out_value
);

    // A result offered and not taken stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result item withdrawn while stalled");

    // Name fields only on symbol characters
    a_name_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_out_kind != KIND_SYM)) |->
            ((i_out_name_char == 8'h00) && !i_out_name_last))
        else $error("name field set on a non-symbol item");

    // Value only on constants
    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_out_kind != KIND_CONST)) |-> (i_out_value == 32'h0))
        else $error("value set on a non-constant item");

    // Reset empties the result queue
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered just after reset");

    // With nothing queued the input side is open
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_out_valid && $past(i_rst_n)) |-> i_in_ready)
        else $error("input stalled with an empty result queue");

endmodule

bind s_expression_lexer_unit sel_checker u_sel_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_kind      (o_out.kind),
    .i_out_name_char (o_out.name_char),
    .i_out_name_last (o_out.name_last),
    .i_out_value     (o_out.value)
);
